// ===== hdl/ffsh_pkg.sv =====
// shared types, constants and round functions for the feed-forward sponge hash
package ffsh_pkg;

    localparam int ROW_TOTAL = 24;
    localparam int ABSORB_ROWS = 8;
    localparam int RC_COUNT = 40;
    localparam logic [7:0] PAD_BYTE = 8'hFF;

    typedef logic [127:0] row_t;
    typedef row_t [ROW_TOTAL-1:0] state_t;

    function automatic logic [6:0] rot_amount(input int i);
        logic [6:0] r;
        case (i)
            0: r = 7'd1;    1: r = 7'd16;   2: r = 7'd55;   3: r = 7'd118;
            4: r = 7'd10;   5: r = 7'd29;   6: r = 7'd72;   7: r = 7'd11;
            8: r = 7'd35;   9: r = 7'd58;   10: r = 7'd105; 11: r = 7'd48;
            12: r = 7'd76;  13: r = 7'd103; 14: r = 7'd26;  15: r = 7'd101;
            16: r = 7'd5;   17: r = 7'd36;  18: r = 7'd91;  19: r = 7'd42;
            20: r = 7'd78;  21: r = 7'd113; 22: r = 7'd44;  default: r = 7'd127;
        endcase
        return r;
    endfunction

    function automatic logic [127:0] round_const(input logic [5:0] rnd);
        logic [127:0] c;
        case (rnd)
            6'd0:  c = 128'hB7E151628AED2A6A_BF7158809CF4F3C7;
            6'd1:  c = 128'h62E7160F38B4DA56_A784D9045190CFEF;
            6'd2:  c = 128'h324E7738926CFBE5_F4BF8D8D8C31D763;
            6'd3:  c = 128'hDA06C80ABB1185EB_4F7C7B5757F59584;
            6'd4:  c = 128'h90CFD47D7C19BB42_158D9554F7B46BCE;
            6'd5:  c = 128'hD55C4D79FD5F24D6_613C31C3839A2DDF;
            6'd6:  c = 128'h8A9A276BCFBFA1C8_77C56284DAB79CD4;
            6'd7:  c = 128'hC2B3293D20E9E5EA_F02AC60ACC93ED87;
            6'd8:  c = 128'h4422A52ECB238FEE_E5AB6ADD835FD1A0;
            6'd9:  c = 128'h753D0A8F78E537D2_B95BB79D8DCAEC64;
            6'd10: c = 128'h2C1E9F23B829B5C2_780BF38737DF8BB3;
            6'd11: c = 128'h00D01334A0D0BD86_45CBFA73A6160FFE;
            6'd12: c = 128'h393C48CBBBCA060F_0FF8EC6D31BEB5CC;
            6'd13: c = 128'hEED7F2F0BB088017_163BC60DF45A0ECB;
            6'd14: c = 128'h1BCD289B06CBBFEA_21AD08E1847F3F73;
            6'd15: c = 128'h78D56CED94640D6E_F0D3D37BE67008E1;
            6'd16: c = 128'h86D1BF275B9B241D_EB64749A47DFDFB9;
            6'd17: c = 128'h6632C3EB061B6472_BBF84C26144E49C2;
            6'd18: c = 128'hD04C324EF10DE513_D3F5114B8B5D374D;
            6'd19: c = 128'h93CB8879C7D52FFD_72BA0AAE7277DA7B;
            6'd20: c = 128'hA1B4AF1488D8E836_AF14865E6C37AB68;
            6'd21: c = 128'h76FE690B57112138_2AF341AFE94F77BC;
            6'd22: c = 128'hF06C83B8FF5675F0_979074AD9A787BC5;
            6'd23: c = 128'hB9BD4B0C5937D3ED_E4C3A79396215EDA;
            6'd24: c = 128'hB1F57D0B5A7DB461_DD8F3C75540D0012;
            6'd25: c = 128'h1FD56E95F8C731E9_C4D7221BBED0C62B;
            6'd26: c = 128'hB5A87804B679A0CA_A41D802A4604C311;
            6'd27: c = 128'hB71DE3E5C6B400E0_24A6668CCF2E2DE8;
            6'd28: c = 128'h6876E4F5C50000F0_A93B3AA7E6342B30;
            6'd29: c = 128'h2A0A47373B25F73E_3B26D569FE2291AD;
            6'd30: c = 128'h36D6A147D1060B87_1A2801F978376408;
            6'd31: c = 128'h2FF592D9140DB1E9_399DF4B0E14CA8E8;
            6'd32: c = 128'h8EE9110B2BD4FA98_EED150CA6DD89322;
            6'd33: c = 128'h45EF7592C703F532_CE3A30CD31C070EB;
            6'd34: c = 128'h36B4195FF33FB1C6_6C7D70F93918107C;
            6'd35: c = 128'hE2051FED33F6D1DE_9491C7DEA6A5A442;
            6'd36: c = 128'hE154C8BB6D8D0362_803BC248D414478C;
            6'd37: c = 128'h2AFB07FFE78E89B9_FECA7E3060C08F0D;
            6'd38: c = 128'h61F8E36801DF66D1_D8F9392E52CAEF06;
            default: c = 128'h53199479DF2BE64B_BAAB008CA8A06FDA;
        endcase
        return c;
    endfunction

    // one full round of the permutation, shared by every absorb and final pass
    function automatic state_t round_fn(input state_t s, input logic [5:0] rnd);
        state_t t;
        state_t o;
        logic [127:0] all;
        int f;
        int k;
        int src[6][4];
        int dst[6];
        src = '{'{4, 9, 18, 23}, '{8, 1, 22, 15}, '{12, 17, 6, 3},
                '{20, 5, 10, 19}, '{0, 21, 14, 11}, '{16, 13, 2, 7}};
        dst = '{0, 4, 8, 12, 16, 20};
        for (int i = 0; i < ROW_TOTAL; i++) begin
            t[i] = s[i] ^ s[(i + 8) % ROW_TOTAL]
                 ^ (s[(i + 4) % ROW_TOTAL] & s[(i + 12) % ROW_TOTAL]);
            if (((i / 4) % 3) != 2) t[i] = ~t[i];
        end
        for (f = 0; f < 6; f++) begin
            all = t[src[f][0]] ^ t[src[f][1]] ^ t[src[f][2]] ^ t[src[f][3]];
            for (k = 0; k < 4; k++) o[dst[f] + k] = all ^ t[src[f][k]];
        end
        for (int i = 0; i < ROW_TOTAL; i++)
            o[i] = (o[i] << rot_amount(i)) | (o[i] >> (7'd0 - rot_amount(i)));
        o[ROW_TOTAL-1] = o[ROW_TOTAL-1] ^ round_const(rnd);
        return o;
    endfunction

endpackage

// ===== hdl/feedforward_sponge_hash_1024_top.sv =====
// top level of the feed-forward sponge hash with 1024-bit digest
// An accepted chunk beat keeps s_ready low through the accept, the writing of its valid
// bytes one at a time into the block buffer, and a decision step. When the 128-byte block
// fills, the shared round unit runs ROUND_COUNT rounds, one round per cycle, then a fold
// first adds the saved capacity rows and then reads the block back one 64-bit word per
// cycle into the rate rows. A last beat with a partial block adds a padding step and
// another permutation and fold, padding bytes being substituted as the words are read
// back; then a decision step, a closing ROUND_COUNT-round pass and 16 digest beats on the
// m_ channel, one per cycle while m_ready is high. s_ready is low while any of this is in
// progress. The length register (len_reg, written through cfg_we) is sampled into row 23
// when the first beat of a message arrives.
module feedforward_sponge_hash_1024_top #(
    parameter int ROUND_COUNT = 40
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [63:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_chunk_data,
    input  logic [3:0]  s_chunk_bytes,
    input  logic        s_chunk_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest_word,
    output logic [3:0]  m_digest_index,
    output logic        m_digest_last
);
    import ffsh_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_BYTES, ST_PAD, ST_PERM, ST_FOLD, ST_OUT
    } fsm_t;

    fsm_t         state_reg;
    logic [63:0]  len_reg;
    state_t       rows_reg;
    state_t       saved_reg;
    logic [63:0]  buf_reg [16];        // block buffer, one word per 8 bytes
    logic [63:0]  word_reg;            // registered buffer read
    logic [6:0]   fill_reg;            // buffered bytes
    logic         open_reg;
    logic [63:0]  data_reg;
    logic [3:0]   left_reg;            // bytes of the beat still to absorb
    logic         last_reg;
    logic         final_reg;           // permutation is the closing pass
    logic [5:0]   rnd_reg;
    logic [3:0]   idx_reg;
    logic         padded_reg;
    logic [4:0]   fold_reg;            // fold step, 0 is the capacity step
    logic [3:0]   fold_w;              // buffer word held in word_reg
    logic [63:0]  fold_word;           // that word with padding applied

    localparam logic [5:0] LAST_RND = 6'(ROUND_COUNT - 1);

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_digest_index = idx_reg;
    assign m_digest_last = (idx_reg == 4'd15);
    assign m_digest_word = idx_reg[0] ? rows_reg[idx_reg[3:1]][127:64]
                                      : rows_reg[idx_reg[3:1]][63:0];

    assign fold_w = fold_reg[3:0] - 4'd1;

    // bytes at or past the fill point of a padded block read as the pad byte
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            if (padded_reg && ({fold_w, 3'(b)} >= fill_reg))
                fold_word[8*b +: 8] = PAD_BYTE;
            else
                fold_word[8*b +: 8] = word_reg[8*b +: 8];
        end
    end

    // byte writes into the buffer, one word read per cycle
    always_ff @(posedge aclk) begin
        if (state_reg == ST_BYTES && left_reg != 4'd0) begin
            buf_reg[fill_reg[6:3]][{fill_reg[2:0], 3'b000} +: 8] <= data_reg[7:0];
        end
        word_reg <= buf_reg[fold_reg[3:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            fill_reg   <= '0;
            open_reg   <= 1'b0;
            idx_reg    <= '0;
            rnd_reg    <= '0;
            final_reg  <= 1'b0;
            padded_reg <= 1'b0;
            fold_reg   <= '0;
            len_reg    <= '0;
        end else begin
            if (cfg_we) len_reg <= cfg_wdata;
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        data_reg  <= s_chunk_data;
                        left_reg  <= (s_chunk_bytes > 4'd8) ? 4'd8 : s_chunk_bytes;
                        last_reg  <= s_chunk_last;
                        padded_reg <= 1'b0;
                        if (!open_reg) begin
                            rows_reg <= {row_t'({64'd0, len_reg}),
                                         {(ROW_TOTAL-1){128'd0}}};
                            fill_reg <= '0;
                            open_reg <= 1'b1;
                        end
                        state_reg <= ST_BYTES;
                    end
                end
                ST_BYTES: begin
                    if (left_reg != 4'd0) begin
                        data_reg <= data_reg >> 8;
                        left_reg <= left_reg - 4'd1;
                        fill_reg <= fill_reg + 7'd1;
                        if (fill_reg == 7'd127) begin
                            saved_reg <= rows_reg;
                            rnd_reg   <= '0;
                            final_reg <= 1'b0;
                            state_reg <= ST_PERM;
                        end
                    end else if (!last_reg) begin
                        state_reg <= ST_IDLE;
                    end else if (fill_reg != 7'd0 && !padded_reg) begin
                        state_reg <= ST_PAD;
                    end else begin
                        rnd_reg   <= '0;
                        final_reg <= 1'b1;
                        state_reg <= ST_PERM;
                    end
                end
                ST_PAD: begin
                    padded_reg <= 1'b1;
                    saved_reg  <= rows_reg;
                    rnd_reg    <= '0;
                    final_reg  <= 1'b0;
                    state_reg  <= ST_PERM;
                end
                ST_PERM: begin
                    rows_reg <= round_fn(rows_reg, rnd_reg);
                    rnd_reg  <= rnd_reg + 6'd1;
                    if (rnd_reg == LAST_RND) begin
                        idx_reg   <= '0;
                        fold_reg  <= '0;
                        state_reg <= final_reg ? ST_OUT : ST_FOLD;
                    end
                end
                ST_FOLD: begin
                    // feed-forward on capacity rows, then block words into rate rows
                    if (fold_reg == 5'd0) begin
                        for (int i = ABSORB_ROWS; i < ROW_TOTAL; i++)
                            rows_reg[i] <= rows_reg[i] ^ saved_reg[i];
                    end else if (fold_w[0]) begin
                        rows_reg[fold_w[3:1]][127:64] <= rows_reg[fold_w[3:1]][127:64]
                                                         ^ fold_word;
                    end else begin
                        rows_reg[fold_w[3:1]][63:0] <= rows_reg[fold_w[3:1]][63:0]
                                                       ^ fold_word;
                    end
                    if (fold_reg == 5'd16) begin
                        fill_reg  <= '0;
                        state_reg <= ST_BYTES;
                    end else begin
                        fold_reg <= fold_reg + 5'd1;
                    end
                end
                ST_OUT: begin
                    if (m_ready) begin
                        idx_reg <= idx_reg + 4'd1;
                        if (idx_reg == 4'd15) begin
                            open_reg  <= 1'b0;
                            fill_reg  <= '0;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // no new beat while digest words are pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("input and output busy together");
    // digest ends by returning to idle
    a_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_digest_last) |=> s_ready)
        else $error("no return to idle after digest");
    // round counter stays in range
    a_rnd: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PERM) |-> (rnd_reg <= LAST_RND))
        else $error("round counter overrun");

endmodule
